FILE: sv/sit_pkg.sv
// ----------------------------------------------------------------------------
// sit_pkg
// Shared types and constants for the sorted interval table: field widths,
// request and status codes, the sequencer states and the stored slot layout.
// ----------------------------------------------------------------------------
package sit_pkg;

    localparam int TIME_W       = 12;
    localparam int TAG_W        = 16;
    localparam int STATUS_W     = 4;
    localparam int COUNT_W      = 5;
    localparam int IDX_W        = 4;
    localparam int REQ_W        = 2;
    localparam int CAPACITY_DEF = 16;

    // 24.00 h in hundredths of an hour
    localparam logic [TIME_W-1:0] TIME_LIMIT = TIME_W'(2400);

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_EXISTS = 2'd2,
        REQ_READ   = 2'd3
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 4'd0,
        ST_INVALID   = 4'd1,
        ST_OVERLAP   = 4'd2,
        ST_FULL      = 4'd3,
        ST_EMPTY     = 4'd4,
        ST_NOT_FOUND = 4'd5,
        ST_EXISTS    = 4'd6,
        ST_ABSENT    = 4'd7,
        ST_BAD       = 4'd8
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_GROW,
        S_SHRINK,
        S_FETCH
    } state_t;

    typedef struct packed {
        logic [TIME_W-1:0] slot_begin;
        logic [TIME_W-1:0] slot_end;
        logic [TAG_W-1:0]  slot_tag;
    } slot_t;

    // result of comparing one stored slot against the request key
    typedef struct packed {
        logic overlap;
        logic equal;
        logic greater;
    } cmp_t;

endpackage

FILE: sv/sorted_interval_table_unit.sv
// ----------------------------------------------------------------------------
// sorted_interval_table_unit
// Table of up to CAPACITY intervals kept sorted by begin, with insert
// (validity, overlap and capacity checks), remove by begin, exists query and
// indexed read. One shared compare unit walks the table under a sequencer.
// ----------------------------------------------------------------------------
//  channel   | handshake           | word
//  ----------+---------------------+--------------------------------------------
//  request   | start & !busy       | req_type begin_time end_time tag_value
//            |                     | entry_index
//  result    | done (1 cycle)      | status entry_count read_begin read_end
//            |                     | read_tag
//
//  Rejections found from the request alone answer without a scan; read fetches
//  one slot; exists, insert and remove walk the stored entries, paced by the
//  single read port of the slot memory (one slot a cycle during the scan and
//  during the shift).
//  Reset clears the count and the sequencer; slot contents need no clearing.
//  Result strobe rises as busy drops or, for a rejection, in idle; never held.
// ----------------------------------------------------------------------------
module sorted_interval_table_unit
    import sit_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [REQ_W-1:0]    req_type,
    input  logic [TIME_W-1:0]   begin_time,
    input  logic [TIME_W-1:0]   end_time,
    input  logic [TAG_W-1:0]    tag_value,
    input  logic [IDX_W-1:0]    entry_index,
    output logic                done,
    output logic [STATUS_W-1:0] status,
    output logic [COUNT_W-1:0]  entry_count,
    output logic [TIME_W-1:0]   read_begin,
    output logic [TIME_W-1:0]   read_end,
    output logic [TAG_W-1:0]    read_tag
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CW > IDX_W) ? CW : IDX_W;

    // slot memory
    slot_t mem [CAPACITY];
    slot_t rd_data_reg;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    slot_t         wr_data;

    // sequencer and request
    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     ptr_reg, ptr_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [AW-1:0]     pend_idx_reg, pend_idx_next;
    req_t              req_reg, req_next;
    logic [TIME_W-1:0] key_begin_reg, key_begin_next;
    logic [TIME_W-1:0] key_end_reg, key_end_next;
    logic [TAG_W-1:0]  key_tag_reg, key_tag_next;

    // result word
    logic              done_reg, done_next;
    status_t           status_reg, status_next;
    logic [COUNT_W-1:0] entry_count_reg, entry_count_next;
    slot_t             read_reg, read_next;

    logic    fin;
    status_t fin_status;
    logic    fin_read;
    logic    issue;
    cmp_t    cmp;
    slot_t   new_slot;

    sit_cmp u_cmp (
        .entry_begin (rd_data_reg.slot_begin),
        .entry_end   (rd_data_reg.slot_end),
        .key_begin   (key_begin_reg),
        .key_end     (key_end_reg),
        .result      (cmp)
    );

    assign new_slot = '{slot_begin: key_begin_reg, slot_end: key_end_reg,
                        slot_tag: key_tag_reg};

    // sequencer next state
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        pend_valid_next = 1'b0;
        pend_idx_next   = pend_idx_reg;
        req_next        = req_reg;
        key_begin_next  = key_begin_reg;
        key_end_next    = key_end_reg;
        key_tag_next    = key_tag_reg;
        rd_en           = 1'b0;
        rd_addr         = ptr_reg[AW-1:0];
        wr_en           = 1'b0;
        wr_addr         = pend_idx_reg;
        wr_data         = rd_data_reg;
        fin             = 1'b0;
        fin_status      = ST_OK;
        fin_read        = 1'b0;
        issue           = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next       = req_t'(req_type);
                    key_begin_next = begin_time;
                    key_end_next   = end_time;
                    key_tag_next   = tag_value;
                    ptr_next       = '0;
                    unique case (req_t'(req_type))
                        REQ_INSERT:
                        begin
                            if ((begin_time >= end_time) || (end_time > TIME_LIMIT))
                            begin
                                fin        = 1'b1;
                                fin_status = ST_INVALID;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        REQ_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                fin        = 1'b1;
                                fin_status = ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        REQ_EXISTS:
                        begin
                            if (begin_time > TIME_LIMIT)
                            begin
                                fin        = 1'b1;
                                fin_status = ST_BAD;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        REQ_READ:
                        begin
                            if (IW'(entry_index) < IW'(count_reg))
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = AW'(entry_index);
                                state_next = S_FETCH;
                            end
                            else
                            begin
                                fin        = 1'b1;
                                fin_status = ST_BAD;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // walk the table, one read issued per cycle, compared the cycle after
            S_SCAN:
            begin
                issue = (ptr_reg < count_reg);
                if (issue)
                begin
                    rd_en           = 1'b1;
                    ptr_next        = ptr_reg + CW'(1);
                    pend_valid_next = 1'b1;
                    pend_idx_next   = ptr_reg[AW-1:0];
                end
                if (pend_valid_reg &&
                    ((req_reg == REQ_INSERT) ? cmp.overlap : cmp.equal))
                begin
                    pend_valid_next = 1'b0;
                    priority case (req_reg)
                        REQ_INSERT:
                        begin
                            fin        = 1'b1;
                            fin_status = ST_OVERLAP;
                            state_next = S_IDLE;
                        end
                        REQ_EXISTS:
                        begin
                            fin        = 1'b1;
                            fin_status = ST_EXISTS;
                            state_next = S_IDLE;
                        end
                        default:
                        begin
                            // remove: close the gap from the slot above the match
                            ptr_next   = CW'(pend_idx_reg) + CW'(1);
                            state_next = S_SHRINK;
                        end
                    endcase
                end
                else if (!issue && !pend_valid_reg)
                begin
                    priority case (req_reg)
                        REQ_INSERT:
                        begin
                            if (count_reg >= CW'(CAPACITY))
                            begin
                                fin        = 1'b1;
                                fin_status = ST_FULL;
                                state_next = S_IDLE;
                            end
                            else
                            begin
                                ptr_next   = count_reg;
                                state_next = S_GROW;
                            end
                        end
                        REQ_REMOVE:
                        begin
                            fin        = 1'b1;
                            fin_status = ST_NOT_FOUND;
                            state_next = S_IDLE;
                        end
                        default:
                        begin
                            fin        = 1'b1;
                            fin_status = ST_ABSENT;
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // shift larger slots up from the top, then drop the new slot in
            S_GROW:
            begin
                issue = (ptr_reg != '0);
                if (issue)
                begin
                    rd_en           = 1'b1;
                    rd_addr         = AW'(ptr_reg - CW'(1));
                    ptr_next        = ptr_reg - CW'(1);
                    pend_valid_next = 1'b1;
                    pend_idx_next   = AW'(ptr_reg - CW'(1));
                end
                if (pend_valid_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = pend_idx_reg + AW'(1);
                    if (!cmp.greater)
                    begin
                        wr_data         = new_slot;
                        pend_valid_next = 1'b0;
                        count_next      = count_reg + CW'(1);
                        fin             = 1'b1;
                        state_next      = S_IDLE;
                    end
                end
                else if (!issue)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = '0;
                    wr_data    = new_slot;
                    count_next = count_reg + CW'(1);
                    fin        = 1'b1;
                    state_next = S_IDLE;
                end
            end

            // move each slot above the removed one down by one
            S_SHRINK:
            begin
                issue = (ptr_reg < count_reg);
                if (issue)
                begin
                    rd_en           = 1'b1;
                    ptr_next        = ptr_reg + CW'(1);
                    pend_valid_next = 1'b1;
                    pend_idx_next   = ptr_reg[AW-1:0];
                end
                if (pend_valid_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = pend_idx_reg - AW'(1);
                end
                else if (!issue)
                begin
                    count_next = count_reg - CW'(1);
                    fin        = 1'b1;
                    state_next = S_IDLE;
                end
            end

            // read data is back: report it
            S_FETCH:
            begin
                fin        = 1'b1;
                fin_read   = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // result word
        done_next        = fin;
        status_next      = fin ? fin_status : status_reg;
        entry_count_next = fin ? COUNT_W'(count_next) : entry_count_reg;
        read_next        = fin ? (fin_read ? rd_data_reg : '0) : read_reg;
    end

    // hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            ptr_reg        <= '0;
            pend_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            ptr_reg        <= ptr_next;
            pend_valid_reg <= pend_valid_next;
            done_reg       <= done_next;
        end
    end

    // hold request and result words
    always_ff @(posedge clk)
    begin
        pend_idx_reg    <= pend_idx_next;
        req_reg         <= req_next;
        key_begin_reg   <= key_begin_next;
        key_end_reg     <= key_end_next;
        key_tag_reg     <= key_tag_next;
        status_reg      <= status_next;
        entry_count_reg <= entry_count_next;
        read_reg        <= read_next;
    end

    // slot memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign entry_count = entry_count_reg;
    assign read_begin  = read_reg.slot_begin;
    assign read_end    = read_reg.slot_end;
    assign read_tag    = read_reg.slot_tag;

endmodule

FILE: sv/sit_cmp.sv
// ----------------------------------------------------------------------------
// sit_cmp
// Shared compare unit: checks one stored slot against the request key for
// overlap (touching endpoints included), equal begin and greater begin.
// ----------------------------------------------------------------------------
module sit_cmp
    import sit_pkg::*;
(
    input  logic [TIME_W-1:0] entry_begin,
    input  logic [TIME_W-1:0] entry_end,
    input  logic [TIME_W-1:0] key_begin,
    input  logic [TIME_W-1:0] key_end,
    output cmp_t              result
);

    // overlap when key begin falls inside the slot or slot begin inside the key
    always_comb
    begin
        result.overlap = ((key_begin >= entry_begin) && (key_begin <= entry_end)) ||
                         ((entry_begin >= key_begin) && (entry_begin <= key_end));
        result.equal   = (entry_begin == key_begin);
        result.greater = (entry_begin > key_begin);
    end

endmodule

FILE: sv/sit_checker.sv
// ----------------------------------------------------------------------------
// sit_checker
// Port-level checks on the sorted interval table: request/result sequencing,
// zeroed read fields on a failed request and single steps of the entry count.
// ----------------------------------------------------------------------------
module sit_checker
    import sit_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                done,
    input logic [STATUS_W-1:0] status,
    input logic [COUNT_W-1:0]  entry_count,
    input logic [TIME_W-1:0]   read_begin,
    input logic [TIME_W-1:0]   read_end,
    input logic [TAG_W-1:0]    read_tag
);

    // a result is only shown once the block is free again
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    // an accepted word either starts work or answers at once
    a_start_acts: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted word produced neither work nor result");

    // busy only rises from an accepted word
    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a request");

    // read fields stay zero unless the request succeeded
    a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != ST_OK)) |->
            ((read_begin == '0) && (read_end == '0) && (read_tag == '0)))
        else $error("read fields nonzero on a failed request");

    // the count moves by at most one between back-to-back results
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(done)) |->
            ((entry_count == $past(entry_count)) ||
             (entry_count == $past(entry_count) + COUNT_W'(1)) ||
             (entry_count == $past(entry_count) - COUNT_W'(1))))
        else $error("entry count jumped");

endmodule

bind sorted_interval_table_unit sit_checker u_sit_checker (.*);
